// ===== design/pcst_pkg.sv =====
// pcst_pkg: shared types, constants and scan code tables for the pc to st translator
// used by pcst_lookup, pcst_core and pc_to_st_scancode_translator_unit
`default_nettype none

package pcst_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 14;

    // entry flag positions
    localparam int FLG_NUMPAD_BIT = 8;
    localparam int FLG_CTRL_BIT   = 9;
    localparam int FLG_PAUSE_BIT  = 10;
    localparam int FLG_SHIFT_BIT  = 11;
    localparam int FLG_PRTSCR_BIT = 12;
    localparam int FLG_JOY_BIT    = 13;

    localparam logic [ENTRY_W-1:0] FLG_NUMPAD = ENTRY_W'(14'h0100);
    localparam logic [ENTRY_W-1:0] FLG_CTRL   = ENTRY_W'(14'h0200);
    localparam logic [ENTRY_W-1:0] FLG_PAUSE  = ENTRY_W'(14'h0400);
    localparam logic [ENTRY_W-1:0] FLG_SHIFT  = ENTRY_W'(14'h0800);
    localparam logic [ENTRY_W-1:0] FLG_PRTSCR = ENTRY_W'(14'h1000);
    localparam logic [ENTRY_W-1:0] FLG_JOY    = ENTRY_W'(14'h2000);

    localparam logic [7:0]       SCAN_PREFIX  = 8'he0;
    localparam logic [7:0]       SCAN_NUMLOCK = 8'h45;
    localparam logic [IDX_W-1:0] LOW_LED_ACK  = IDX_W'(7'h7a);
    localparam logic [IDX_W-1:0] LOW_CTRL     = IDX_W'(7'h1d);

    localparam logic [6:0] ST_UP    = 7'h48;
    localparam logic [6:0] ST_DOWN  = 7'h50;
    localparam logic [6:0] ST_LEFT  = 7'h4b;
    localparam logic [6:0] ST_RIGHT = 7'h4d;
    localparam logic [6:0] ST_FIRE  = 7'h1d;

    // configuration register indexes
    localparam logic [1:0] CFG_BREAK_KEY    = 2'd0;
    localparam logic [1:0] CFG_SELECTOR_KEY = 2'd1;
    localparam logic [1:0] CFG_LEDS_ENABLE  = 2'd2;
    localparam logic [1:0] CFG_LAPTOP_MODE  = 2'd3;

    localparam logic [6:0] BREAK_KEY_RST    = 7'd41;
    localparam logic [7:0] SELECTOR_KEY_RST = 8'd88;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_USER_BREAK = 3'd1,
        EV_SELECTOR   = 3'd2,
        EV_PRTSCR     = 3'd3,
        EV_HARD_RESET = 3'd4,
        EV_SOFT_RESET = 3'd5
    } t_event;

    typedef struct packed {
        logic [6:0] break_key_code;
        logic [7:0] selector_key_code;
        logic       leds_enable;
        logic       laptop_mode;
    } t_cfg;

    // packed lowest field last so the struct matches tdata order
    typedef struct packed {
        logic [2:0] led_value;
        logic       led_valid;
        logic [7:0] joystick_mask;
        t_event     event_res;
        logic [7:0] key_code;
        logic       key_valid;
    } t_result;

    function automatic logic [ENTRY_W-1:0] normal_map(input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] e;
        e = '0;
        unique case (idx)
            7'h1d:   e = FLG_CTRL | ENTRY_W'(7'h1d);
            7'h2a:   e = FLG_SHIFT | ENTRY_W'(7'h2a);
            7'h36:   e = FLG_SHIFT | ENTRY_W'(7'h36);
            7'h37:   e = ENTRY_W'(7'h66);
            7'h45:   e = '0;
            7'h46:   e = FLG_PRTSCR;
            7'h47:   e = FLG_NUMPAD | ENTRY_W'(7'h67);
            7'h48:   e = FLG_NUMPAD | ENTRY_W'(7'h68);
            7'h49:   e = FLG_NUMPAD | ENTRY_W'(7'h69);
            7'h4a:   e = FLG_NUMPAD | ENTRY_W'(7'h4a);
            7'h4b:   e = FLG_NUMPAD | ENTRY_W'(7'h6a);
            7'h4c:   e = FLG_NUMPAD | ENTRY_W'(7'h6b);
            7'h4d:   e = FLG_NUMPAD | ENTRY_W'(7'h6c);
            7'h4e:   e = FLG_NUMPAD | ENTRY_W'(7'h4e);
            7'h4f:   e = FLG_NUMPAD | ENTRY_W'(7'h6d);
            7'h50:   e = FLG_NUMPAD | ENTRY_W'(7'h6e);
            7'h51:   e = FLG_NUMPAD | ENTRY_W'(7'h6f);
            7'h52:   e = FLG_NUMPAD | ENTRY_W'(7'h70);
            7'h53:   e = FLG_NUMPAD | ENTRY_W'(7'h71);
            7'h56:   e = ENTRY_W'(7'h60);
            default: begin
                if (idx <= 7'h44) begin
                    e = ENTRY_W'(idx);
                end else begin
                    e = '0;
                end
            end
        endcase
        return e;
    endfunction

    function automatic logic [ENTRY_W-1:0] extended_map(input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] e;
        e = '0;
        unique case (idx)
            7'h1c:   e = ENTRY_W'(7'h72);
            7'h1d:   e = FLG_NUMPAD | FLG_CTRL | FLG_JOY | ENTRY_W'(7'h1d);
            7'h35:   e = ENTRY_W'(7'h65);
            7'h38:   e = ENTRY_W'(7'h38);
            7'h46:   e = FLG_PAUSE;
            7'h47:   e = ENTRY_W'(7'h47);
            7'h48:   e = FLG_JOY | ENTRY_W'(7'h48);
            7'h49:   e = ENTRY_W'(7'h62);
            7'h4b:   e = FLG_JOY | ENTRY_W'(7'h4b);
            7'h4d:   e = FLG_JOY | ENTRY_W'(7'h4d);
            7'h50:   e = FLG_JOY | ENTRY_W'(7'h50);
            7'h51:   e = ENTRY_W'(7'h61);
            7'h52:   e = ENTRY_W'(7'h52);
            7'h53:   e = ENTRY_W'(7'h53);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== design/pcst_lookup.sv =====
// pcst_lookup: table lookup of one scan code, normal or extended, with laptop ctrl remap
// depends on pcst_pkg tables
`default_nettype none

module pcst_lookup
    import pcst_pkg::*;
(
    input  wire logic [IDX_W-1:0]   i_low,
    input  wire logic               i_ext,
    input  wire logic               i_laptop_mode,
    output logic      [ENTRY_W-1:0] o_entry
);

    logic [ENTRY_W-1:0] raw;

    always_comb begin
        raw = i_ext ? extended_map(i_low) : normal_map(i_low);
        o_entry = raw;
        if (i_low == LOW_CTRL && i_laptop_mode) begin
            if (i_ext) begin
                o_entry = raw & ~FLG_JOY;
            end else begin
                o_entry = raw | FLG_JOY;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/pcst_core.sv =====
// pcst_core: keyboard state (prefix, numlock, modifiers, joystick) and result decode
// depends on pcst_pkg and pcst_lookup
`default_nettype none

module pcst_core
    import pcst_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_scan_byte,
    input  wire logic       i_selector_open,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    logic       r_prefix, r_numlock, r_ctrl, r_pause, r_shift;
    logic [7:0] r_joy;
    logic       n_prefix, n_numlock, n_ctrl, n_pause, n_shift;
    logic [7:0] n_joy;

    logic [ENTRY_W-1:0] entry;
    logic [IDX_W-1:0]   low;
    logic               rel;
    logic [7:0]         joy_bit;

    assign low = i_scan_byte[IDX_W-1:0];
    assign rel = i_scan_byte[7];

    pcst_lookup u_lookup (
        .i_low         (low),
        .i_ext         (r_prefix),
        .i_laptop_mode (i_cfg.laptop_mode),
        .o_entry       (entry)
    );

    always_comb begin
        unique case (entry[6:0])
            ST_UP:    joy_bit = 8'h01;
            ST_DOWN:  joy_bit = 8'h02;
            ST_LEFT:  joy_bit = 8'h04;
            ST_RIGHT: joy_bit = 8'h08;
            ST_FIRE:  joy_bit = 8'h80;
            default:  joy_bit = 8'h00;
        endcase
    end

    always_comb begin
        n_prefix  = (i_scan_byte == SCAN_PREFIX);
        n_numlock = r_numlock;
        n_ctrl    = r_ctrl;
        n_pause   = r_pause;
        n_shift   = r_shift;
        n_joy     = r_joy;
        o_result  = '0;
        o_result.event_res = EV_NONE;

        if (n_prefix || low == LOW_LED_ACK) begin
            o_result.event_res = EV_NONE;
        end else if (low == i_cfg.break_key_code) begin
            o_result.event_res = EV_USER_BREAK;
        end else if (i_scan_byte == i_cfg.selector_key_code && !i_selector_open) begin
            o_result.event_res = EV_SELECTOR;
        end else if (i_scan_byte == SCAN_NUMLOCK) begin
            n_numlock = !r_numlock;
            if (i_cfg.leds_enable) begin
                o_result.led_valid = 1'b1;
                o_result.led_value = {1'b0, n_numlock, 1'b0};
            end
        end else if (entry[FLG_PRTSCR_BIT]) begin
            if (rel) begin
                o_result.event_res = EV_PRTSCR;
            end
        end else begin
            if (entry[FLG_CTRL_BIT])  n_ctrl  = !rel;
            if (entry[FLG_PAUSE_BIT]) n_pause = !rel;
            if (entry[FLG_SHIFT_BIT]) n_shift = !rel;
            if (entry == '0) begin
                o_result.event_res = EV_NONE;
            end else if (entry[FLG_JOY_BIT] && !r_numlock) begin
                if (rel) begin
                    n_joy = r_joy & ~joy_bit;
                end else begin
                    n_joy = r_joy | joy_bit;
                end
            end else if (n_ctrl && n_pause) begin
                o_result.event_res = n_shift ? EV_HARD_RESET : EV_SOFT_RESET;
                n_ctrl  = 1'b0;
                n_pause = 1'b0;
                n_shift = 1'b0;
            end else begin
                o_result.key_valid = 1'b1;
                o_result.key_code  = {rel, entry[6:0]};
            end
        end
        o_result.joystick_mask = n_joy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix  <= 1'b0;
            r_numlock <= 1'b1;
            r_ctrl    <= 1'b0;
            r_pause   <= 1'b0;
            r_shift   <= 1'b0;
            r_joy     <= '0;
        end else if (i_advance) begin
            r_prefix  <= n_prefix;
            r_numlock <= n_numlock;
            r_ctrl    <= n_ctrl;
            r_pause   <= n_pause;
            r_shift   <= n_shift;
            r_joy     <= n_joy;
        end
    end

endmodule

`default_nettype wire

// ===== design/pc_to_st_scancode_translator_unit.sv =====
// pc_to_st_scancode_translator_unit: top level, stream ports, config registers, pipeline regs
// depends on pcst_pkg and pcst_core
`default_nettype none

// Translates PC set-1 scan bytes into ST key codes, one result per request. A request
// passes an input register and then a result register, and the result is valid once it is in the
// result register; a new request is taken every cycle as long as the output side
// keeps taking results; the only per-request work is the table lookup and flag logic
// between the two registers. The result carries the key code, an event code, the
// joystick mask after the request and an optional LED command. Configuration writes
// take effect at once and are meant to happen while no request is in flight.
module pc_to_st_scancode_translator_unit
    import pcst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // scan_byte [7:0], selector_open [8], zero [15:9]
    input  wire logic [15:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // key_valid [0], key_code [8:1], event_res [11:9], joystick_mask [19:12],
    // led_valid [20], led_value [23:21]
    output logic      [23:0] o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    [7:0] r_in_scan;
    logic    r_in_sel;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.break_key_code    <= BREAK_KEY_RST;
            r_cfg.selector_key_code <= SELECTOR_KEY_RST;
            r_cfg.leds_enable       <= 1'b0;
            r_cfg.laptop_mode       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BREAK_KEY:    r_cfg.break_key_code    <= i_cfg_wdata[6:0];
                CFG_SELECTOR_KEY: r_cfg.selector_key_code <= i_cfg_wdata;
                CFG_LEDS_ENABLE:  r_cfg.leds_enable       <= i_cfg_wdata[0];
                CFG_LAPTOP_MODE:  r_cfg.laptop_mode       <= i_cfg_wdata[0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_scan <= i_s_axis_tdata[7:0];
            r_in_sel  <= i_s_axis_tdata[8];
        end
    end

    pcst_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_scan_byte     (r_in_scan),
        .i_selector_open (r_in_sel),
        .i_cfg           (r_cfg),
        .o_result        (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // a prefix byte never produces a key, an event or a LED command
    a_prefix_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_scan == SCAN_PREFIX |=>
            r_out_valid && !r_out.key_valid && r_out.event_res == EV_NONE && !r_out.led_valid)
        else $error("prefix byte produced a result");

    a_key_xor_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.key_valid && r_out.event_res != EV_NONE)
            && !(r_out.key_valid && r_out.led_valid))
        else $error("key and event or led in one result");

    a_led_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.led_valid |-> r_cfg.leds_enable)
        else $error("led command with leds disabled");

    a_joy_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.joystick_mask[6:4] == 3'b000)
        else $error("joystick mask has unused bits set");

endmodule

`default_nettype wire
